// ----- hdl/pcs_pkg.sv -----
// Shared types, constants and helper functions of the paletted cell store.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package pcs_pkg;

    localparam int ID_W       = 16;
    localparam int CELL_W     = 12;
    localparam int WORD_W     = 64;
    localparam int WADDR_W    = 10;
    localparam int WORDS      = 1024;
    localparam int BITS_W     = 5;
    localparam int SHIFT_W    = 6;
    localparam int PAL_DEPTH  = 65536;

    localparam logic [BITS_W-1:0]  START_BITS    = 5'd4;
    localparam logic [BITS_W-1:0]  MID_BITS      = 5'd8;
    localparam logic [BITS_W-1:0]  MAX_BITS      = 5'd16;
    localparam logic [ID_W-1:0]    PALETTE_LIMIT = 16'hFFFF;
    localparam logic [ID_W-1:0]    CAP_START     = 16'd16;
    localparam logic [ID_W-1:0]    CAP_MID       = 16'd256;
    localparam logic [ID_W-1:0]    CLEAR_LAST    = 16'd255;
    localparam logic [ID_W-1:0]    TOP_START     = 16'd255;
    localparam logic [ID_W-1:0]    TOP_MID       = 16'd511;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_SLOT,
        S_RD_PAL,
        S_CLEAR,
        S_SRCH_ISSUE,
        S_SRCH_CMP,
        S_GROW_CHECK,
        S_RP_READ,
        S_RP_LO,
        S_RP_HI,
        S_APPEND,
        S_WR_READ,
        S_WR_MOD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic make_explicit;
        logic clear_wr;
        logic word_rd;
        logic word_wr_cell;
        logic rp_read;
        logic rp_lo;
        logic rp_hi;
        logic widen;
        logic idx_clr;
        logic idx_inc;
        logic idx_dec;
        logic idx_load_top;
        logic pal_rd_idx;
        logic pal_rd_slot;
        logic pal_append;
        logic slot_from_idx;
        logic set_rd;
        logic set_ovf;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic uniform;
        logic id_eq_uniform;
        logic idx_eq_size;
        logic idx_zero;
        logic idx_clear_last;
        logic pal_match;
        logic needs_grow;
        logic ovf_cond;
        logic out_free;
    } status_t;

    // Spreads one half of a packed word into a word at twice the slot width.
    function automatic logic [WORD_W-1:0] expand_half(input logic [WORD_W/2-1:0] h,
                                                      input logic from_mid);
        logic [WORD_W-1:0] r;
        r = '0;
        if (!from_mid)
        begin
            for (int i = 0; i < 8; i++)
            begin
                r[i*8 +: 8] = {4'b0, h[i*4 +: 4]};
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                r[i*16 +: 16] = {8'b0, h[i*8 +: 8]};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pcs_ctrl.sv -----
// Sequencing state machine of the paletted cell store.
// Depends on pcs_pkg; drives the datapath through command and status structs.
`default_nettype none
module pcs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pcs_pkg::status_t st,
    output pcs_pkg::cmd_t        cmd
);
    import pcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.op == OP_READ)
                begin
                    if (st.uniform)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.word_rd = 1'b1;
                        state_next  = S_RD_SLOT;
                    end
                end
                else if (st.uniform && st.id_eq_uniform)
                begin
                    state_next = S_FINISH;
                end
                else if (st.uniform)
                begin
                    cmd.make_explicit = 1'b1;
                    cmd.idx_clr       = 1'b1;
                    state_next        = S_CLEAR;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SRCH_ISSUE;
                end
            end
            S_RD_SLOT:
            begin
                cmd.pal_rd_slot = 1'b1;
                state_next      = S_RD_PAL;
            end
            S_RD_PAL:
            begin
                cmd.set_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.idx_clear_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SRCH_ISSUE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SRCH_ISSUE:
            begin
                if (st.idx_eq_size)
                begin
                    state_next = S_GROW_CHECK;
                end
                else
                begin
                    cmd.pal_rd_idx = 1'b1;
                    state_next     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (st.pal_match)
                begin
                    cmd.slot_from_idx = 1'b1;
                    state_next        = S_WR_READ;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRCH_ISSUE;
                end
            end
            S_GROW_CHECK:
            begin
                if (st.needs_grow)
                begin
                    cmd.idx_load_top = 1'b1;
                    state_next       = S_RP_READ;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_RP_READ:
            begin
                cmd.rp_read = 1'b1;
                state_next  = S_RP_LO;
            end
            S_RP_LO:
            begin
                cmd.rp_lo  = 1'b1;
                state_next = S_RP_HI;
            end
            S_RP_HI:
            begin
                cmd.rp_hi = 1'b1;
                if (st.idx_zero)
                begin
                    cmd.widen  = 1'b1;
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_RP_READ;
                end
            end
            S_APPEND:
            begin
                if (st.ovf_cond)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.pal_append = 1'b1;
                    state_next     = S_WR_READ;
                end
            end
            S_WR_READ:
            begin
                cmd.word_rd = 1'b1;
                state_next  = S_WR_MOD;
            end
            S_WR_MOD:
            begin
                cmd.word_wr_cell = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/pcs_datapath.sv -----
// Datapath of the paletted cell store: section state, palette and word memories.
// Depends on pcs_pkg; obeys the command struct from pcs_ctrl.
`default_nettype none
module pcs_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pcs_pkg::cmd_t                cmd,
    output pcs_pkg::status_t                  st,
    input  wire logic                         cfg_valid,
    input  wire logic [pcs_pkg::ID_W-1:0]     cfg_data,
    input  wire logic                         in_op,
    input  wire logic [pcs_pkg::CELL_W-1:0]   in_cell,
    input  wire logic [pcs_pkg::ID_W-1:0]     in_id,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [pcs_pkg::ID_W-1:0]          out_read_id,
    output logic                              out_uniform,
    output logic [pcs_pkg::BITS_W-1:0]        out_bits,
    output logic [pcs_pkg::ID_W-1:0]          out_count,
    output logic                              out_ovf
);
    import pcs_pkg::*;

    logic               uniform_reg;
    logic [ID_W-1:0]    uniform_id_reg;
    logic [BITS_W-1:0]  width_reg;
    logic [ID_W-1:0]    size_reg;
    logic               op_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    idx_reg;
    logic [ID_W-1:0]    slot_reg;
    logic [ID_W-1:0]    rd_reg;
    logic               ovf_reg;
    logic [WORD_W-1:0]  hold_reg;
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_read_id_reg;
    logic               out_uniform_reg;
    logic [BITS_W-1:0]  out_bits_reg;
    logic [ID_W-1:0]    out_count_reg;
    logic               out_ovf_reg;

    logic [ID_W-1:0]    pal_mem [PAL_DEPTH];
    logic [ID_W-1:0]    pal_rdata_reg;
    logic [ID_W-1:0]    pal_addr;
    logic [ID_W-1:0]    pal_wdata;
    logic               pal_we;

    logic [WORD_W-1:0]  word_mem [WORDS];
    logic [WORD_W-1:0]  word_rdata_reg;
    logic [WADDR_W-1:0] word_addr;
    logic [WORD_W-1:0]  word_wdata;
    logic               word_we;

    logic [WADDR_W-1:0] cell_addr;
    logic [SHIFT_W-1:0] cell_shift;
    logic [ID_W-1:0]    slot_mask;
    logic [ID_W-1:0]    cur_slot;
    logic [WORD_W-1:0]  slot_field;
    logic [WORD_W-1:0]  mask_field;
    logic               full;
    logic               from_mid;

    always_comb
    begin
        case (width_reg)
            START_BITS:
            begin
                cell_addr  = {2'b0, cell_reg[11:4]};
                cell_shift = {cell_reg[3:0], 2'b0};
                slot_mask  = 16'h000F;
            end
            MID_BITS:
            begin
                cell_addr  = {1'b0, cell_reg[11:3]};
                cell_shift = {cell_reg[2:0], 3'b0};
                slot_mask  = 16'h00FF;
            end
            default:
            begin
                cell_addr  = cell_reg[11:2];
                cell_shift = {cell_reg[1:0], 4'b0};
                slot_mask  = 16'hFFFF;
            end
        endcase
    end

    assign cur_slot   = ID_W'(word_rdata_reg >> cell_shift) & slot_mask;
    assign slot_field = {48'b0, slot_reg & slot_mask} << cell_shift;
    assign mask_field = {48'b0, slot_mask} << cell_shift;
    assign full       = ((width_reg == START_BITS) && (size_reg >= CAP_START))
                     || ((width_reg == MID_BITS) && (size_reg >= CAP_MID));
    assign from_mid   = (width_reg == MID_BITS);

    always_comb
    begin
        pal_we    = 1'b0;
        pal_wdata = id_reg;
        pal_addr  = idx_reg;
        if (cmd.make_explicit)
        begin
            pal_we    = 1'b1;
            pal_wdata = uniform_id_reg;
            pal_addr  = '0;
        end
        else if (cmd.pal_append)
        begin
            pal_we   = 1'b1;
            pal_addr = size_reg;
        end
        else if (cmd.pal_rd_slot)
        begin
            pal_addr = cur_slot;
        end
    end

    always_comb
    begin
        word_we    = 1'b0;
        word_wdata = '0;
        word_addr  = cell_addr;
        if (cmd.clear_wr)
        begin
            word_we   = 1'b1;
            word_addr = idx_reg[WADDR_W-1:0];
        end
        else if (cmd.rp_read)
        begin
            word_addr = idx_reg[WADDR_W-1:0];
        end
        else if (cmd.rp_lo)
        begin
            word_we    = 1'b1;
            word_addr  = {idx_reg[WADDR_W-2:0], 1'b0};
            word_wdata = expand_half(word_rdata_reg[WORD_W/2-1:0], from_mid);
        end
        else if (cmd.rp_hi)
        begin
            word_we    = 1'b1;
            word_addr  = {idx_reg[WADDR_W-2:0], 1'b1};
            word_wdata = expand_half(hold_reg[WORD_W-1:WORD_W/2], from_mid);
        end
        else if (cmd.word_wr_cell)
        begin
            word_we    = 1'b1;
            word_wdata = (word_rdata_reg & ~mask_field) | slot_field;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_addr] <= pal_wdata;
        end
        pal_rdata_reg <= pal_mem[pal_addr];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_wdata;
        end
        word_rdata_reg <= word_mem[word_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uniform_reg    <= 1'b1;
            uniform_id_reg <= '0;
            width_reg      <= '0;
            size_reg       <= 16'd1;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (uniform_reg)
                begin
                    uniform_id_reg <= cfg_data;
                end
            end
            if (cmd.make_explicit)
            begin
                uniform_reg <= 1'b0;
                width_reg   <= START_BITS;
                size_reg    <= 16'd1;
            end
            if (cmd.widen)
            begin
                width_reg <= {width_reg[BITS_W-2:0], 1'b0};
            end
            if (cmd.pal_append)
            begin
                size_reg <= size_reg + 16'd1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_load_top)
            begin
                idx_reg <= (width_reg == START_BITS) ? TOP_START : TOP_MID;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 16'd1;
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - 16'd1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= in_op;
            cell_reg <= in_cell;
            id_reg   <= in_id;
            rd_reg   <= (in_op == OP_READ && uniform_reg) ? uniform_id_reg : '0;
            ovf_reg  <= 1'b0;
        end
        if (cmd.set_rd)
        begin
            rd_reg <= pal_rdata_reg;
        end
        if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.slot_from_idx)
        begin
            slot_reg <= idx_reg;
        end
        if (cmd.pal_append)
        begin
            slot_reg <= size_reg;
        end
        if (cmd.rp_lo)
        begin
            hold_reg <= word_rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_read_id_reg <= rd_reg;
            out_uniform_reg <= uniform_reg;
            out_bits_reg    <= width_reg;
            out_count_reg   <= size_reg;
            out_ovf_reg     <= ovf_reg;
        end
    end

    always_comb
    begin
        st.op             = op_reg;
        st.uniform        = uniform_reg;
        st.id_eq_uniform  = (id_reg == uniform_id_reg);
        st.idx_eq_size    = (idx_reg == size_reg);
        st.idx_zero       = (idx_reg == '0);
        st.idx_clear_last = (idx_reg == CLEAR_LAST);
        st.pal_match      = (pal_rdata_reg == id_reg);
        st.needs_grow     = full;
        st.ovf_cond       = (size_reg == PALETTE_LIMIT) || full;
        st.out_free       = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_read_id = out_read_id_reg;
    assign out_uniform = out_uniform_reg;
    assign out_bits    = out_bits_reg;
    assign out_count   = out_count_reg;
    assign out_ovf     = out_ovf_reg;

endmodule
`default_nettype wire

// ----- hdl/paletted_cell_store_unit.sv -----
// Top level of the paletted cell store: joins pcs_ctrl and pcs_datapath.
// Depends on pcs_pkg, pcs_ctrl and pcs_datapath.
//
// One 4096-cell section held as a palette of 16-bit block ids and packed slot
// indices. A read answers with the fill id while the section is uniform and
// otherwise reads the slot word, then the palette entry. A write searches the
// palette entry by entry, so its time grows with the palette size; leaving
// uniform mode first clears 256 words, and a width growth repacks the word
// memory from the top down, each old word into two (256 old words from 4 to 8
// bits, 512 from 8 to 16). The palette and word memories are single-port. The
// result waits in an output register, so the next item may be taken while it
// is unread. The fill id may be written at any time the block holds no item.
`default_nettype none
module paletted_cell_store_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [11:0] cell_index,
    input  wire logic [15:0] write_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      read_block_id,
    output logic             is_uniform,
    output logic [4:0]       entry_bits,
    output logic [15:0]      palette_count,
    output logic             write_refused
);
    import pcs_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    pcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pcs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_op       (op),
        .in_cell     (cell_index),
        .in_id       (write_id),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_read_id (read_block_id),
        .out_uniform (is_uniform),
        .out_bits    (entry_bits),
        .out_count   (palette_count),
        .out_ovf     (write_refused)
    );

endmodule
`default_nettype wire

// ----- sim/paletted_cell_store_checker.sv -----
// Checker for the paletted cell store: watches the configuration, input and
// result channels, predicts every result and compares it field by field.
// Depends on pcs_pkg for the operation codes.
`default_nettype none
module paletted_cell_store_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        op,
    input  wire logic [11:0] cell_index,
    input  wire logic [15:0] write_id,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] read_block_id,
    input  wire logic        is_uniform,
    input  wire logic [4:0]  entry_bits,
    input  wire logic [15:0] palette_count,
    input  wire logic        write_refused,
    output int               failures,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] rd_id;
        logic        uni;
        logic [4:0]  width;
        logic [15:0] pal_size;
        logic        ovf;
    } cell_result_t;

    cell_result_t result_queue[$];

    logic        sec_uniform;
    logic [15:0] sec_uniform_id;
    logic [4:0]  sec_width;
    int          sec_pal_size;
    logic [15:0] sec_palette[65536];
    int          sec_slot[4096];

    task automatic report(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        failures++;
    endtask

    task automatic predict_cell_access(input logic rw, input logic [11:0] cell_idx,
                                       input logic [15:0] id);
        cell_result_t res;
        int           slot;
        int           cap;
        logic         found;
        res = '0;
        slot = 0;
        found = 1'b0;
        if (rw == pcs_pkg::OP_READ)
        begin
            res.rd_id = sec_uniform ? sec_uniform_id : sec_palette[sec_slot[cell_idx]];
        end
        else if (!(sec_uniform && id == sec_uniform_id))
        begin
            if (sec_uniform)
            begin
                for (int c = 0; c < 4096; c++)
                begin
                    sec_slot[c] = 0;
                end
                sec_palette[0] = sec_uniform_id;
                sec_pal_size = 1;
                sec_width = 5'd4;
                sec_uniform = 1'b0;
            end
            for (int i = 0; i < sec_pal_size && !found; i++)
            begin
                if (sec_palette[i] == id)
                begin
                    slot = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                cap = 1 << sec_width;
                if (sec_pal_size >= cap && sec_width < 5'd16)
                begin
                    sec_width = 5'(sec_width * 2);
                    cap = 1 << sec_width;
                end
                if (sec_pal_size >= 65535 || sec_pal_size >= cap)
                begin
                    res.ovf = 1'b1;
                end
                else
                begin
                    slot = sec_pal_size;
                    sec_palette[slot] = id;
                    sec_pal_size++;
                end
            end
            if (!res.ovf)
            begin
                sec_slot[cell_idx] = slot;
            end
        end
        res.uni = sec_uniform;
        res.width = sec_uniform ? 5'd0 : sec_width;
        res.pal_size = sec_pal_size[15:0];
        result_queue.insert(result_queue.size(), res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n)
        begin
            sec_uniform = 1'b1;
            sec_uniform_id = '0;
            sec_width = '0;
            sec_pal_size = 1;
            result_queue.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (sec_uniform)
                begin
                    sec_uniform_id = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                predict_cell_access(op, cell_index, write_id);
            end
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    report("unexpected word", 1, 0);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (read_block_id != want.rd_id)
                        report("read_block_id", read_block_id, want.rd_id);
                    if (is_uniform != want.uni)
                        report("is_uniform", is_uniform, want.uni);
                    if (entry_bits != want.width)
                        report("entry_bits", entry_bits, want.width);
                    if (palette_count != want.pal_size)
                        report("palette_count", palette_count, want.pal_size);
                    if (write_refused != want.ovf)
                        report("write_refused", write_refused, want.ovf);
                end
            end
            pending = result_queue.size();
        end
    end

    initial
    begin
        failures = 0;
    end
endmodule
`default_nettype wire

// ----- sim/paletted_cell_store_unit_test.sv -----
// Testbench top for the paletted cell store: drives reads, writes and fill id
// changes under varying idle patterns and gives the verdict.
// Depends on pcs_pkg, paletted_cell_store_unit and paletted_cell_store_checker.
`default_nettype none
module paletted_cell_store_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [11:0] cell_index;
    logic [15:0] write_id;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] read_block_id;
    logic        is_uniform;
    logic [4:0]  entry_bits;
    logic [15:0] palette_count;
    logic        write_refused;
    int          failures;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          quiet_cycles;
    logic [15:0] written_ids[$];

    paletted_cell_store_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .cell_index     (cell_index),
        .write_id       (write_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_block_id  (read_block_id),
        .is_uniform     (is_uniform),
        .entry_bits     (entry_bits),
        .palette_count  (palette_count),
        .write_refused  (write_refused)
    );

    paletted_cell_store_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .cell_index     (cell_index),
        .write_id       (write_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_block_id  (read_block_id),
        .is_uniform     (is_uniform),
        .entry_bits     (entry_bits),
        .palette_count  (palette_count),
        .write_refused  (write_refused),
        .failures       (failures),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic rw, input logic [11:0] cell_idx, input logic [15:0] id);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= rw;
        cell_index <= cell_idx;
        write_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_fill(input logic [15:0] id);
        drain();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= id;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_words(input int count);
        logic [15:0] id;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            if ($urandom_range(99) < 30)
            begin
                send_word(pcs_pkg::OP_READ, 12'($urandom()), 16'($urandom()));
            end
            else
            begin
                if (written_ids.size() == 0 || $urandom_range(99) < 35)
                begin
                    id = 16'($urandom());
                    written_ids.insert(written_ids.size(), id);
                end
                else
                begin
                    id = written_ids[$urandom_range(written_ids.size() - 1)];
                end
                send_word(pcs_pkg::OP_WRITE, 12'($urandom()), id);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = pcs_pkg::OP_READ;
        cell_index = '0;
        write_id = '0;
        send_idle = 35;
        recv_idle = 65;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pcs_pkg::OP_READ, 12'd3, 16'hFFFF);
        write_fill(16'hFFFF);
        send_word(pcs_pkg::OP_READ, 12'd0, 16'h0000);
        send_word(pcs_pkg::OP_READ, 12'hFFF, 16'h0000);
        send_word(pcs_pkg::OP_WRITE, 12'hFFF, 16'hFFFF);
        send_word(pcs_pkg::OP_WRITE, 12'd0, 16'h0000);
        send_word(pcs_pkg::OP_READ, 12'd0, 16'h0000);
        send_word(pcs_pkg::OP_READ, 12'hFFF, 16'h0000);
        send_word(pcs_pkg::OP_WRITE, 12'hFFF, 16'hFFFF);
        for (int k = 1; k <= 16; k++)
        begin
            send_word(pcs_pkg::OP_WRITE, 12'(k * 255), 16'(k * 4097));
        end
        send_word(pcs_pkg::OP_READ, 12'd255, 16'h0000);
        send_word(pcs_pkg::OP_READ, 12'hFF0, 16'h0000);

        send_idle = 35;
        recv_idle = 65;
        random_words(480);
        write_fill(16'h0000);
        send_idle = 65;
        recv_idle = 35;
        random_words(480);
        write_fill(16'h5AA5);
        send_idle = 0;
        recv_idle = 0;
        random_words(490);

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/pcs_pkg.sv
hdl/pcs_ctrl.sv
hdl/pcs_datapath.sv
hdl/paletted_cell_store_unit.sv
sim/paletted_cell_store_checker.sv
sim/paletted_cell_store_unit_test.sv
